// ===== rtl/core/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types for the priority ready queue: request and status codes and
// the per-cycle control word broadcast to the slot cells.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int HANDLE_W   = 3;
    localparam int PRIORITY_W = 8;
    localparam int OCC_W      = 4;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/priority_ready_queue_core.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_core
// Ready queue sorted by descending priority, first-in-first-out among ties.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per transaction: insert (handle plus
//   priority) or remove head. m_ channel returns one result per request:
//   status, popped handle and priority (zero unless a remove succeeded) and
//   the occupancy after the request.
//   Storage is a row of DEPTH slot cells; each cell compares its priority
//   with the incoming one in parallel and shifts to a neighbor, so a request
//   is finished in the cycle it is accepted.
//   Result is registered and valid in the cycle after acceptance.
//   Throughput: one request per cycle while m_ready is high.
//   A result waiting in the output register is held while m_ready is low;
//   s_ready then drops until that result is taken.
//   Reset empties the queue (count to zero) and clears m_valid; slot
//   contents are not cleared. Insert on a full queue reports STATUS_FULL,
//   remove on an empty queue STATUS_EMPTY; neither changes the queue.
// ----------------------------------------------------------------------------
module priority_ready_queue_core
    import prq_pkg::*;
#(
    parameter int DEPTH = 8
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [HANDLE_W-1:0]   s_entry_handle,
    input  logic [PRIORITY_W-1:0] s_entry_priority,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [HANDLE_W-1:0]   m_head_handle,
    output logic [PRIORITY_W-1:0] m_head_priority,
    output logic [OCC_W-1:0]      m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg, status_next;
    logic [HANDLE_W-1:0]   head_handle_reg, head_handle_next;
    logic [PRIORITY_W-1:0] head_priority_reg, head_priority_next;
    logic [OCC_W-1:0]      occupancy_reg, occupancy_next;

    logic       s_fire;
    logic       is_remove;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    logic                  ge_w  [DEPTH];
    logic [HANDLE_W-1:0]   hnd_w [DEPTH];
    logic [PRIORITY_W-1:0] pri_w [DEPTH];

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign is_remove = (req_t'(s_req_type) == REQ_REMOVE);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);

    assign ctrl.insert = s_fire && !is_remove && !is_full;
    assign ctrl.remove = s_fire && is_remove && !is_empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  left_ge;
        logic [HANDLE_W-1:0]   left_handle,  right_handle;
        logic [PRIORITY_W-1:0] left_priority, right_priority;

        if (i == 0) begin : g_first
            assign left_ge       = 1'b0;
            assign left_handle   = s_entry_handle;
            assign left_priority = s_entry_priority;
        end else begin : g_mid
            assign left_ge       = ge_w[i-1];
            assign left_handle   = hnd_w[i-1];
            assign left_priority = pri_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_handle   = hnd_w[i];
            assign right_priority = pri_w[i];
        end else begin : g_inner
            assign right_handle   = hnd_w[i+1];
            assign right_priority = pri_w[i+1];
        end

        prq_cell u_cell (
            .aclk           (aclk),
            .ctrl           (ctrl),
            .occupied       (count_reg > CNT_W'(i)),
            .new_handle     (s_entry_handle),
            .new_priority   (s_entry_priority),
            .left_ge        (left_ge),
            .left_handle    (left_handle),
            .left_priority  (left_priority),
            .right_handle   (right_handle),
            .right_priority (right_priority),
            .ge             (ge_w[i]),
            .handle         (hnd_w[i]),
            .priority_out   (pri_w[i])
        );
    end

    always_comb begin
        count_next         = count_reg;
        m_valid_next       = m_valid_reg;
        status_next        = status_reg;
        head_handle_next   = head_handle_reg;
        head_priority_next = head_priority_reg;
        occupancy_next     = occupancy_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            m_valid_next       = 1'b1;
            status_next        = STATUS_OK;
            head_handle_next   = '0;
            head_priority_next = '0;
            if (is_remove) begin
                if (is_empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    head_handle_next   = hnd_w[0];
                    head_priority_next = pri_w[0];
                    count_next         = count_reg - 1'b1;
                end
            end else begin
                if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            occupancy_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg        <= status_next;
        head_handle_reg   <= head_handle_next;
        head_priority_reg <= head_priority_next;
        occupancy_reg     <= occupancy_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_head_handle   = head_handle_reg;
    assign m_head_priority = head_priority_reg;
    assign m_occupancy     = occupancy_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.insert |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow queue");

    a_remove_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && is_remove && is_empty |=> m_status == STATUS_EMPTY && count_reg == '0)
        else $error("remove on empty not flagged");

    a_fail_zero_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_head_handle == '0 && m_head_priority == '0)
        else $error("failed request returned head data");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_FULL |-> m_occupancy == OCC_W'(DEPTH))
        else $error("full status with wrong occupancy");

endmodule

// ===== rtl/core/prq_cell.sv =====
// ----------------------------------------------------------------------------
// prq_cell
// One queue slot. Holds a handle and priority, flags whether a new entry
// belongs at or before it, and shifts toward the tail on insert or toward
// the head on remove.
// ----------------------------------------------------------------------------
module prq_cell
    import prq_pkg::*;
(
    input  logic                  aclk,
    input  cell_ctrl_t            ctrl,
    input  logic                  occupied,
    input  logic [HANDLE_W-1:0]   new_handle,
    input  logic [PRIORITY_W-1:0] new_priority,
    input  logic                  left_ge,
    input  logic [HANDLE_W-1:0]   left_handle,
    input  logic [PRIORITY_W-1:0] left_priority,
    input  logic [HANDLE_W-1:0]   right_handle,
    input  logic [PRIORITY_W-1:0] right_priority,
    output logic                  ge,
    output logic [HANDLE_W-1:0]   handle,
    output logic [PRIORITY_W-1:0] priority_out
);

    logic [HANDLE_W-1:0]   handle_reg,   handle_next;
    logic [PRIORITY_W-1:0] priority_reg, priority_next;

    // at or past the insert point: empty, or strictly lower priority
    assign ge = !occupied || (priority_reg < new_priority);

    always_comb begin
        handle_next   = handle_reg;
        priority_next = priority_reg;
        if (ctrl.insert && ge) begin
            if (left_ge) begin
                handle_next   = left_handle;
                priority_next = left_priority;
            end else begin
                handle_next   = new_handle;
                priority_next = new_priority;
            end
        end else if (ctrl.remove) begin
            handle_next   = right_handle;
            priority_next = right_priority;
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg   <= handle_next;
        priority_reg <= priority_next;
    end

    assign handle       = handle_reg;
    assign priority_out = priority_reg;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for priority_ready_queue_core. A driver plays a list
// of insert/remove requests (a directed opening, then random runs that fill,
// drain or stay balanced), a software copy of the sorted queue predicts
// each result, and a monitor compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import prq_pkg::*;

    localparam int QUEUE_DEPTH    = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int SEGMENTS       = 48;
    localparam int SEGMENT_LEN    = 40;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_LEN       = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        req_t                  req;
        logic [HANDLE_W-1:0]   handle;
        logic [PRIORITY_W-1:0] prio;
    } queue_request_t;

    typedef struct {
        status_t               status;
        logic [HANDLE_W-1:0]   handle;
        logic [PRIORITY_W-1:0] prio;
        logic [OCC_W-1:0]      occupancy;
    } queue_result_t;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic                  s_req_type       = 1'b0;
    logic [HANDLE_W-1:0]   s_entry_handle   = '0;
    logic [PRIORITY_W-1:0] s_entry_priority = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [1:0]            m_status;
    logic [HANDLE_W-1:0]   m_head_handle;
    logic [PRIORITY_W-1:0] m_head_priority;
    logic [OCC_W-1:0]      m_occupancy;

    queue_request_t        pending_requests[$];
    queue_result_t         expected_results[$];

    logic [HANDLE_W-1:0]   queue_handle[QUEUE_DEPTH];
    logic [PRIORITY_W-1:0] queue_priority[QUEUE_DEPTH];
    int                    queue_count  = 0;

    int  errors          = 0;
    int  inputs_accepted = 0;
    int  send_gap        = 0;
    int  rx_gap          = 0;
    int  hold_cycles     = 0;
    bit  hold_done       = 1'b0;
    int  idle_cycles     = 0;

    priority_ready_queue_core #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_entry_handle  (s_entry_handle),
        .s_entry_priority(s_entry_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_head_handle   (m_head_handle),
        .m_head_priority (m_head_priority),
        .m_occupancy     (m_occupancy)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones, and stretches with none at all
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (((inputs_accepted / 250) % 3) == 2) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_request(req_t req, int handle, int prio);
        queue_request_t item;
        item.req    = req;
        item.handle = handle[HANDLE_W-1:0];
        item.prio   = prio[PRIORITY_W-1:0];
        pending_requests.push_back(item);
    endfunction

    // sorted insert behind equal priorities, pop from the head
    function automatic void apply_request(queue_request_t item);
        queue_result_t res;
        int            pos;
        res.status = STATUS_OK;
        res.handle = '0;
        res.prio   = '0;
        if (item.req == REQ_REMOVE) begin
            if (queue_count == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.handle = queue_handle[0];
                res.prio   = queue_priority[0];
                for (int i = 1; i < queue_count; i++) begin
                    queue_handle[i-1]   = queue_handle[i];
                    queue_priority[i-1] = queue_priority[i];
                end
                queue_count--;
            end
        end else begin
            if (queue_count >= QUEUE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                pos = queue_count;
                for (int i = 0; i < queue_count; i++) begin
                    if (queue_priority[i] < item.prio) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = queue_count; i > pos; i--) begin
                    queue_handle[i]   = queue_handle[i-1];
                    queue_priority[i] = queue_priority[i-1];
                end
                queue_handle[pos]   = item.handle;
                queue_priority[pos] = item.prio;
                queue_count++;
            end
        end
        res.occupancy = queue_count[OCC_W-1:0];
        expected_results.push_back(res);
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        queue_request_t item;
        bit             busy;
        busy = s_valid && !s_ready;
        if (aresetn && !busy) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                item = pending_requests.pop_front();
                s_valid          <= 1'b1;
                s_req_type       <= item.req;
                s_entry_handle   <= item.handle;
                s_entry_priority <= item.prio;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the queue up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else if (!hold_done && inputs_accepted >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_cycles <= HOLD_LEN;
            m_ready     <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_gap  <= pick_gap();
        end
    end

    // monitor: predict on request transactions, check result transactions
    always @(posedge aclk) begin
        queue_request_t item;
        queue_result_t  want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                item.req    = req_t'(s_req_type);
                item.handle = s_entry_handle;
                item.prio   = s_entry_priority;
                apply_request(item);
                inputs_accepted <= inputs_accepted + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, status %0d occupancy %0d",
                             $time, m_status, m_occupancy);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, m_status);
                    compare_field("head_handle", want.handle, m_head_handle);
                    compare_field("head_priority", want.prio, m_head_priority);
                    compare_field("occupancy", want.occupancy, m_occupancy);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("** priority_ready_queue_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int insert_pct;
        int r;
        int prio;
        req_t req;

        // empty remove, fill with ties and extremes, overfill, drain past empty
        add_request(REQ_REMOVE, 0, 0);
        add_request(REQ_INSERT, 7, 255);
        add_request(REQ_INSERT, 0, 0);
        add_request(REQ_INSERT, 1, 100);
        add_request(REQ_INSERT, 2, 100);
        add_request(REQ_INSERT, 3, 100);
        add_request(REQ_INSERT, 4, 128);
        add_request(REQ_INSERT, 5, 1);
        add_request(REQ_INSERT, 6, 254);
        add_request(REQ_INSERT, 0, 255);
        add_request(REQ_INSERT, 7, 0);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
            add_request(REQ_REMOVE, 7, 255);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            r = $urandom_range(0, 2);
            insert_pct = (r == 0) ? 20 : (r == 1) ? 50 : 80;
            for (int i = 0; i < SEGMENT_LEN; i++) begin
                req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
                case ($urandom_range(0, 3))
                    0: prio = $urandom_range(0, 255);
                    1: prio = $urandom_range(120, 123);
                    2: prio = ($urandom_range(0, 1) == 0) ? 0 : 255;
                    default: prio = $urandom_range(0, 3) * 64;
                endcase
                add_request(req, $urandom_range(0, 7), prio);
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("** priority_ready_queue_core: PASSED **");
        end else begin
            $display("** priority_ready_queue_core: FAILED **");
        end
        $finish;
    end

endmodule
